/* rtl/core/rcpcs_pkg.sv */
// Package for the RC pulse capture and scaler block: payload structs, field widths,
// command and register codes. No dependencies; used by every file in rtl/core.
`default_nettype none

package rcpcs_pkg;

   localparam int CHANNELS_DEFAULT = 4;
   localparam int PIN_N            = 4;
   localparam int CMD_W            = 2;
   localparam int SEL_W            = 3;
   localparam int TIME_W           = 32;
   localparam int WIDTH_W          = 16;
   localparam int VALUE_W          = 14;
   localparam int CENTER_W         = 12;
   localparam int MARGIN_W         = 10;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 12;

   // Output swing on each side of the center value.
   localparam int SPAN_OUT         = 500;
   // Quotient bits: the scaled offset never exceeds SPAN_OUT, so nine bits hold it.
   localparam int QUO_W            = 9;
   localparam int NUM_W            = WIDTH_W + QUO_W;

   localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ESC_CENTER    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_MARGIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK         = 2'd2;

   localparam logic [CENTER_W-1:0] ESC_CENTER_RESET    = 12'd1500;
   localparam logic [MARGIN_W-1:0] CENTER_MARGIN_RESET = 10'd50;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [PIN_N-1:0]  pin_levels;
      logic [TIME_W-1:0] timestamp_us;
      logic [SEL_W-1:0]  channel_select;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] converted_value;
      logic [WIDTH_W-1:0]        raw_width;
      logic [PIN_N-1:0]          centered_mask;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/core/rcpcs_div.sv */
// Iterative restoring divider shared by all channels of the pulse scaler.
// Depends on rcpcs_pkg for the numerator, divisor and quotient widths.
`default_nettype none

module rcpcs_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rcpcs_pkg::NUM_W-1:0]   numer,
   input  wire logic [rcpcs_pkg::WIDTH_W-1:0] denom,
   output logic                               done,
   output logic [rcpcs_pkg::QUO_W-1:0]        quot
);

   localparam int QW   = rcpcs_pkg::QUO_W;
   localparam int WW   = rcpcs_pkg::WIDTH_W;
   localparam int NW   = rcpcs_pkg::NUM_W;
   localparam int CNT_W = $clog2(QW + 1);

   logic              active_ff, active_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WW-1:0]     rem_ff, rem_in;
   logic [QW-1:0]     low_ff, low_in;
   logic [QW-1:0]     quot_ff, quot_in;
   logic [WW-1:0]     den_ff, den_in;

   logic [WW:0]       trial;
   logic [WW:0]       trial_sub;
   logic              fits;

   // The caller guarantees numer < denom * 2^QUO_W, so the upper numerator bits
   // already form a remainder below the divisor and only QUO_W steps remain.
   always_comb begin
      trial     = {rem_ff, low_ff[QW-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});

      active_in = active_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      low_in    = low_ff;
      quot_in   = quot_ff;
      den_in    = den_ff;

      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(QW);
         rem_in    = numer[NW-1:QW];
         low_in    = numer[QW-1:0];
         quot_in   = '0;
         den_in    = denom;
      end else if (active_ff && (cnt_ff != '0)) begin
         rem_in  = fits ? trial_sub[WW-1:0] : trial[WW-1:0];
         low_in  = {low_ff[QW-2:0], 1'b0};
         quot_in = {quot_ff[QW-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
      end else if (active_ff) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign done = active_ff && (cnt_ff == '0);
   assign quot = quot_ff;

endmodule

`default_nettype wire

/* rtl/core/rc_pulse_capture_scaler_unit.sv */
// Flow: a sample, a capture, an unused command code or a read that needs no scaling
// passes from setup straight to the output register; a scaled read also passes through
// the multiply and the 9 steps of the shared divider. One item is in flight at a time, so
// a new item is taken only once the last result is loaded; a stalled result holds
// the next item off. Reset (synchronous, active high) clears all channel state and loads
// the register defaults. Top level of the RC pulse capture and scaler; uses rcpcs_pkg, rcpcs_div.
`default_nettype none

module rc_pulse_capture_scaler_unit #(
   parameter int CHANNELS = rcpcs_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire rcpcs_pkg::req_type               req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output rcpcs_pkg::rsp_type                    rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rcpcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rcpcs_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int WW     = rcpcs_pkg::WIDTH_W;
   localparam int TW     = rcpcs_pkg::TIME_W;
   localparam int VW     = rcpcs_pkg::VALUE_W;
   localparam int QW     = rcpcs_pkg::QUO_W;
   localparam int NW     = rcpcs_pkg::NUM_W;
   localparam int PN     = rcpcs_pkg::PIN_N;
   localparam int CW     = rcpcs_pkg::CENTER_W;
   localparam int MW     = rcpcs_pkg::MARGIN_W;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   // Channels beyond the physical pins always see a low level.
   localparam int LVL_W  = (CHANNELS > PN) ? CHANNELS : PN;
   // Only the first PIN_N channels report in the centered mask.
   localparam int MASK_N = (CHANNELS < PN) ? CHANNELS : PN;

   // The sequencer walks one item through setup and, for a scaled read, the multiply
   // and the divider, then through the output register.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   rcpcs_pkg::req_type req_ff, req_in;

   // Configuration registers.
   logic [CW-1:0]      esc_center_ff, esc_center_in;
   logic [MW-1:0]      margin_ff, margin_in;
   logic               track_ff, track_in;

   // Per-channel state, each entry updated in parallel by a pin sample.
   logic               level_ff  [CHANNELS];
   logic               level_in  [CHANNELS];
   logic [TW-1:0]      rise_ff   [CHANNELS];
   logic [TW-1:0]      rise_in   [CHANNELS];
   logic [WW-1:0]      width_ff  [CHANNELS];
   logic [WW-1:0]      width_in  [CHANNELS];
   logic [WW-1:0]      center_ff [CHANNELS];
   logic [WW-1:0]      center_in [CHANNELS];
   logic [WW-1:0]      low_ff    [CHANNELS];
   logic [WW-1:0]      low_in    [CHANNELS];
   logic [WW-1:0]      high_ff   [CHANNELS];
   logic [WW-1:0]      high_in   [CHANNELS];

   // Operands handed from setup to the multiply and divide steps.
   logic [WW-1:0]      diff_ff, diff_in;
   logic [WW-1:0]      span_ff, span_in;
   logic               neg_ff, neg_in;
   logic [VW-1:0]      val_ff, val_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rcpcs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [LVL_W-1:0]   levels_ext;
   logic               sel_valid;
   logic [CH_W-1:0]    ch_idx;
   logic [WW-1:0]      act, cm, lo, hi;
   logic               degenerate;
   logic [WW-1:0]      conv_diff, conv_span;
   logic               conv_neg;
   logic               rsp_load;
   logic [VW-1:0]      ctr_ext;
   logic [VW-1:0]      quot_ext;
   logic [MASK_N-1:0]  mask_vec;

   logic               div_start;
   logic [NW-1:0]      div_numer;
   logic               div_done;
   logic [QW-1:0]      div_quot;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign levels_ext = LVL_W'(req_ff.pin_levels);
   assign sel_valid  = (req_ff.channel_select != '0)
                       && (int'(req_ff.channel_select) <= CHANNELS);
   assign ch_idx     = CH_W'(req_ff.channel_select - 3'd1);
   assign ctr_ext    = VW'(esc_center_ff);
   assign quot_ext   = VW'(div_quot);
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // The multiply by the output span feeds the divider, whose load registers
   // close the path.
   assign div_start  = (state_ff == ST_MUL);
   assign div_numer  = NW'(diff_ff) * NW'(rcpcs_pkg::SPAN_OUT);

   rcpcs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (span_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Read setup: pick the side of the center the width lies on, clamp it to
   // that side's mark, and flag a zero or inverted span, which gives the center.
   always_comb begin
      act        = width_ff[ch_idx];
      cm         = center_ff[ch_idx];
      lo         = low_ff[ch_idx];
      hi         = high_ff[ch_idx];
      degenerate = 1'b1;
      conv_diff  = '0;
      conv_span  = '0;
      conv_neg   = 1'b0;
      if (act < cm) begin
         degenerate = !(lo < cm);
         conv_span  = cm - lo;
         conv_diff  = cm - ((act < lo) ? lo : act);
         conv_neg   = 1'b1;
      end else if (act > cm) begin
         degenerate = !(hi > cm);
         conv_span  = hi - cm;
         conv_diff  = ((act > hi) ? hi : act) - cm;
      end
   end

   // A channel counts as centered when its width lies strictly inside
   // center plus or minus margin; the lower test is written as w + m > c.
   for (genvar g = 0; g < MASK_N; g++) begin : g_mask
      logic [WW:0] w17, c17, m17;
      assign w17 = {1'b0, width_ff[g]};
      assign c17 = {1'b0, center_ff[g]};
      assign m17 = (WW + 1)'(margin_ff);
      assign mask_vec[g] = (w17 < c17 + m17) && (w17 + m17 > c17);
   end

   always_comb begin
      logic [TW-1:0] dt;
      logic [WW-1:0] wn;

      state_in      = state_ff;
      req_in        = req_ff;
      esc_center_in = esc_center_ff;
      margin_in     = margin_ff;
      track_in      = track_ff;
      diff_in       = diff_ff;
      span_in       = span_ff;
      neg_in        = neg_ff;
      val_in        = val_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      level_in      = level_ff;
      rise_in       = rise_ff;
      width_in      = width_ff;
      center_in     = center_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      dt            = '0;
      wn            = '0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rcpcs_pkg::CSR_ESC_CENTER:    esc_center_in = csr_data[CW-1:0];
            rcpcs_pkg::CSR_CENTER_MARGIN: margin_in     = csr_data[MW-1:0];
            rcpcs_pkg::CSR_TRACK:         track_in      = csr_data[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            val_in   = ctr_ext;
            diff_in  = conv_diff;
            span_in  = conv_span;
            neg_in   = conv_neg;
            state_in = ST_OUT;
            if (req_ff.command == rcpcs_pkg::CMD_SAMPLE) begin
               // Rising edge latches the time; falling edge stores the
               // saturated width and, with tracking on, widens the marks.
               for (int i = 0; i < CHANNELS; i++) begin
                  if (levels_ext[i]) begin
                     if (!level_ff[i]) begin
                        level_in[i] = 1'b1;
                        rise_in[i]  = req_ff.timestamp_us;
                     end
                  end else if (level_ff[i]) begin
                     dt          = req_ff.timestamp_us - rise_ff[i];
                     wn          = (dt[TW-1:WW] != '0) ? '1 : dt[WW-1:0];
                     level_in[i] = 1'b0;
                     width_in[i] = wn;
                     if (track_ff) begin
                        if (wn < low_ff[i])  low_in[i]  = wn;
                        if (wn > high_ff[i]) high_in[i] = wn;
                     end
                  end
               end
            end else if (req_ff.command == rcpcs_pkg::CMD_CAPTURE) begin
               for (int i = 0; i < CHANNELS; i++) begin
                  center_in[i] = width_ff[i];
                  low_in[i]    = width_ff[i];
                  high_in[i]   = width_ff[i];
               end
            end else if (req_ff.command == rcpcs_pkg::CMD_READ
                         && sel_valid && !degenerate) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               val_in   = neg_ff ? (ctr_ext - quot_ext) : (ctr_ext + quot_ext);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.converted_value = val_ff;
               rsp_data_in.raw_width       = sel_valid ? width_ff[ch_idx] : '0;
               rsp_data_in.centered_mask   = PN'(mask_vec);
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         esc_center_ff <= rcpcs_pkg::ESC_CENTER_RESET;
         margin_ff     <= rcpcs_pkg::CENTER_MARGIN_RESET;
         track_ff      <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            level_ff[i]  <= 1'b0;
            rise_ff[i]   <= '0;
            width_ff[i]  <= '0;
            center_ff[i] <= '0;
            low_ff[i]    <= '0;
            high_ff[i]   <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         esc_center_ff <= esc_center_in;
         margin_ff     <= margin_in;
         track_ff      <= track_in;
         level_ff      <= level_in;
         rise_ff       <= rise_in;
         width_ff      <= width_in;
         center_ff     <= center_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
      end
      req_ff      <= req_in;
      diff_ff     <= diff_in;
      span_ff     <= span_in;
      neg_ff      <= neg_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   // An accepted transfer always moves the sequencer into setup.
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("input transfer did not start setup");

   // The divider is only started for a read of a valid channel.
   a_div_only_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (req_ff.command == rcpcs_pkg::CMD_READ && sel_valid))
      else $error("divider started for a non-read item");

   // The clamp keeps the scaled offset within the output span.
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (div_quot <= QW'(rcpcs_pkg::SPAN_OUT)))
      else $error("scaled offset exceeds output span");

   // An out-of-range channel reports a zero raw width.
   a_bad_sel_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !sel_valid) |=> (rsp_data.raw_width == '0))
      else $error("raw width not zero for invalid channel");

endmodule

`default_nettype wire
